[hw/rtl/dps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants for the duplicate packet suppressor.
// ----------------------------------------------------------------------------
package dps_pkg;

	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_ECO_ENABLE      = 2'd0;
	localparam logic [1:0] REG_DUPLICATE_LIMIT = 2'd1;
	localparam logic [1:0] REG_IDLE_THRESHOLD  = 2'd2;
	localparam logic [1:0] REG_STICK_CENTER    = 2'd3;

	localparam logic       RST_ECO_ENABLE      = 1'b1;
	localparam logic [7:0] RST_DUPLICATE_LIMIT = 8'd3;
	localparam logic [9:0] RST_IDLE_THRESHOLD  = 10'd10;
	localparam logic [7:0] RST_STICK_CENTER    = 8'd127;

	typedef struct packed {
		logic       eco_enable;
		logic [7:0] duplicate_limit;
		logic [9:0] idle_threshold;
		logic [7:0] stick_center;
	} cfg_t;

	// finished packet: hash and summed stick deviation
	typedef struct packed {
		logic [31:0] hash;
		logic [9:0]  total;
	} hash_word_t;

endpackage

[hw/rtl/dps_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_regs
// APB register file holding the suppressor configuration.
// ----------------------------------------------------------------------------
module dps_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dps_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output dps_pkg::cfg_t              cfg
);

	dps_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eco_enable      <= dps_pkg::RST_ECO_ENABLE;
			cfg_q.duplicate_limit <= dps_pkg::RST_DUPLICATE_LIMIT;
			cfg_q.idle_threshold  <= dps_pkg::RST_IDLE_THRESHOLD;
			cfg_q.stick_center    <= dps_pkg::RST_STICK_CENTER;
		end else if (wr_en) begin
			unique case (reg_idx)
				dps_pkg::REG_ECO_ENABLE:      cfg_q.eco_enable      <= pwdata[0];
				dps_pkg::REG_DUPLICATE_LIMIT: cfg_q.duplicate_limit <= pwdata[7:0];
				dps_pkg::REG_IDLE_THRESHOLD:  cfg_q.idle_threshold  <= pwdata[9:0];
				dps_pkg::REG_STICK_CENTER:    cfg_q.stick_center    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dps_pkg::REG_ECO_ENABLE:      prdata = {31'd0, cfg_q.eco_enable};
			dps_pkg::REG_DUPLICATE_LIMIT: prdata = {24'd0, cfg_q.duplicate_limit};
			dps_pkg::REG_IDLE_THRESHOLD:  prdata = {22'd0, cfg_q.idle_threshold};
			dps_pkg::REG_STICK_CENTER:    prdata = {24'd0, cfg_q.stick_center};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

[hw/rtl/dps_hash_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_hash_stage
// Input register, FNV-1a round per byte and stick deviation sum.
// ----------------------------------------------------------------------------
module dps_hash_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          packet_byte,
	input  logic                last_byte,
	input  logic [7:0]          aileron_stick,
	input  logic [7:0]          rudder_stick,
	input  logic [7:0]          elevator_stick,
	input  logic [7:0]          stick_center,
	output logic                s2_valid,
	output dps_pkg::hash_word_t s2_word,
	input  logic                s2_free
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [7:0]  ail_s1;
	logic [7:0]  rud_s1;
	logic [7:0]  ele_s1;

	logic [31:0] running_hash_q;
	logic        valid_s2;
	dps_pkg::hash_word_t word_s2;

	logic        adv_s1;
	logic        accept;
	logic [31:0] mix;
	logic [31:0] hash_next;
	logic [7:0]  dev_ail;
	logic [7:0]  dev_rud;
	logic [7:0]  dev_ele;
	logic [9:0]  total;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	assign adv_s1   = valid_s1 & (~last_s1 | s2_free);
	assign in_stall = valid_s1 & ~adv_s1;
	assign accept   = in_valid & ~in_stall;

	assign mix       = running_hash_q ^ {24'd0, byte_s1};
	assign hash_next = mix * dps_pkg::FNV_PRIME;

	assign dev_ail = abs_diff(ail_s1, stick_center);
	assign dev_rud = abs_diff(rud_s1, stick_center);
	assign dev_ele = abs_diff(ele_s1, stick_center);
	assign total   = {2'd0, dev_ail} + {2'd0, dev_rud} + {2'd0, dev_ele};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= packet_byte;
			last_s1 <= last_byte;
			ail_s1  <= aileron_stick;
			rud_s1  <= rudder_stick;
			ele_s1  <= elevator_stick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= dps_pkg::FNV_BASIS;
		end else if (adv_s1) begin
			running_hash_q <= last_s1 ? dps_pkg::FNV_BASIS : hash_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			word_s2.hash  <= hash_next;
			word_s2.total <= total;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_word  = word_s2;

endmodule

[hw/rtl/dps_decide.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_decide
// Send/suppress decision, duplicate tracking and output register.
// ----------------------------------------------------------------------------
module dps_decide (
	input  logic                clk,
	input  logic                arst_n,
	input  dps_pkg::cfg_t       cfg,
	input  logic                s2_valid,
	input  dps_pkg::hash_word_t s2_word,
	output logic                s2_free,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                send_packet,
	output logic [31:0]         packet_hash,
	output logic [7:0]          repeat_count
);

	logic [31:0] prev_hash_q;
	logic [7:0]  dup_count_q;
	logic        out_valid_q;
	logic        send_q;
	logic [31:0] hash_q;
	logic [7:0]  count_q;

	logic        out_free;
	logic        take;
	logic        match;
	logic        suppress;
	logic [7:0]  count_next;

	assign out_free = ~out_valid_q | ~out_stall;
	assign s2_free  = out_free | ~s2_valid;
	assign take     = s2_valid & out_free;

	assign match    = (s2_word.hash == prev_hash_q);
	assign suppress = cfg.eco_enable & match
	                & (dup_count_q >= cfg.duplicate_limit)
	                & (s2_word.total < cfg.idle_threshold);

	always_comb begin
		if (suppress) begin
			count_next = dup_count_q;
		end else if (match) begin
			count_next = (dup_count_q == dps_pkg::COUNT_MAX) ? dup_count_q
			                                                 : dup_count_q + 8'd1;
		end else begin
			count_next = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_hash_q <= 32'd0;
			dup_count_q <= 8'd0;
		end else if (take && !suppress) begin
			prev_hash_q <= s2_word.hash;
			dup_count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			send_q  <= ~suppress;
			hash_q  <= s2_word.hash;
			count_q <= count_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign send_packet  = send_q;
	assign packet_hash  = hash_q;
	assign repeat_count = count_q;

endmodule

[hw/rtl/duplicate_packet_suppressor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_packet_suppressor
// FNV-1a packet hash with suppression of repeated idle command packets.
// ----------------------------------------------------------------------------
//  port group   direction  word
//  in_*         sink       one packet byte, last flag, three stick bytes
//  out_*        source     send decision, packet hash, repeat count
//  p*           APB        eco_enable, duplicate_limit, idle_threshold, stick_center
//
// One byte per clock unless stalled; results pass the s2 and output registers.
// Throughput is set by the per-byte hash round (one constant multiply).
// Reset loads the hash basis and default registers; no clearing time.
// A stalled result is held; input stalls only on a last byte with both stages full.
// ----------------------------------------------------------------------------
module duplicate_packet_suppressor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 packet_byte,
	input  logic                       last_byte,
	input  logic [7:0]                 aileron_stick,
	input  logic [7:0]                 rudder_stick,
	input  logic [7:0]                 elevator_stick,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       send_packet,
	output logic [31:0]                packet_hash,
	output logic [7:0]                 repeat_count,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dps_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	dps_pkg::cfg_t       cfg;
	logic                s2_valid;
	logic                s2_free;
	dps_pkg::hash_word_t s2_word;

	dps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dps_hash_stage u_hash (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.packet_byte    (packet_byte),
		.last_byte      (last_byte),
		.aileron_stick  (aileron_stick),
		.rudder_stick   (rudder_stick),
		.elevator_stick (elevator_stick),
		.stick_center   (cfg.stick_center),
		.s2_valid       (s2_valid),
		.s2_word        (s2_word),
		.s2_free        (s2_free)
	);

	dps_decide u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.s2_valid     (s2_valid),
		.s2_word      (s2_word),
		.s2_free      (s2_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.send_packet  (send_packet),
		.packet_hash  (packet_hash),
		.repeat_count (repeat_count)
	);

endmodule

[hw/rtl/dps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks on result handshake and duplicate bookkeeping.
// ----------------------------------------------------------------------------
module dps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        send_packet,
	input logic [31:0] packet_hash,
	input logic [7:0]  repeat_count
);

	logic [31:0] sent_hash_q;
	logic [7:0]  count_q;
	logic        out_take;

	assign out_take = out_valid & ~out_stall;

	// last sent hash and last reported count, as seen on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_hash_q <= 32'd0;
			count_q     <= 8'd0;
		end else if (out_take) begin
			count_q <= repeat_count;
			if (send_packet) begin
				sent_hash_q <= packet_hash;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(packet_hash) && $stable(repeat_count))
		else $error("stalled result changed");

	a_supp_hash: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_packet |-> packet_hash == sent_hash_q)
		else $error("suppressed packet differs from last sent hash");

	a_supp_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_packet |-> repeat_count == count_q)
		else $error("suppressed packet changed repeat count");

endmodule

bind duplicate_packet_suppressor dps_checker u_dps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.send_packet  (send_packet),
	.packet_hash  (packet_hash),
	.repeat_count (repeat_count)
);
